>>> src/npm_pkg.sv
// ----------------------------------------------------------------------------
// npm_pkg: shared definitions for the nearest point match unit
// Widths, register indexes, command encodings and helper functions used by
// the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package npm_pkg;

   localparam int MAX_POINTS    = 1024;
   localparam int COORD_BITS    = 16;
   localparam int IDX_BITS      = $clog2(MAX_POINTS);
   localparam int USE_BITS      = $clog2(MAX_POINTS + 1);
   localparam int DIST_BITS     = 2 * COORD_BITS + 2;
   localparam int SQ_BITS       = 2 * COORD_BITS;
   localparam int POINT_BITS    = 3 * COORD_BITS;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = DIST_BITS;

   localparam logic [DIST_BITS-1:0] LIMIT_RESET = 34'd12884508675;

   // command queue between front and back end, depth is a power of two
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_POINTS_IN_USE  = 2'd0,
      REG_MATCH_LIMIT_SQ = 2'd1
   } csr_reg_type;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_QUERY = 2'd1,
      OP_SKIP  = 2'd2
   } op_type;

   typedef struct packed {
      op_type                        op;
      logic [IDX_BITS-1:0]           point_index;
      logic signed [COORD_BITS-1:0]  coord_x;
      logic signed [COORD_BITS-1:0]  coord_y;
      logic signed [COORD_BITS-1:0]  coord_z;
   } cmd_type;

   typedef struct packed {
      logic [USE_BITS-1:0]  points_in_use;
      logic [DIST_BITS-1:0] match_limit_sq;
   } cfg_type;

   function automatic logic [COORD_BITS-1:0] abs_diff(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      logic signed [COORD_BITS:0] d;
      logic [COORD_BITS:0]        m;
      d = (COORD_BITS + 1)'(a) - (COORD_BITS + 1)'(b);
      m = d[COORD_BITS] ? unsigned'(-d) : unsigned'(d);
      return m[COORD_BITS-1:0];
   endfunction

endpackage

>>> src/npm_req_if.sv
// ----------------------------------------------------------------------------
// npm_req_if: request channel
// Valid/ready channel carrying one load or query item.
// ----------------------------------------------------------------------------
interface npm_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   kind;
   logic [npm_pkg::IDX_BITS-1:0]           point_index;
   logic signed [npm_pkg::COORD_BITS-1:0]  coord_x;
   logic signed [npm_pkg::COORD_BITS-1:0]  coord_y;
   logic signed [npm_pkg::COORD_BITS-1:0]  coord_z;

   modport source (output valid, kind, point_index, coord_x, coord_y, coord_z,
                   input ready);
   modport sink   (input valid, kind, point_index, coord_x, coord_y, coord_z,
                   output ready);
endinterface

>>> src/npm_rsp_if.sv
// ----------------------------------------------------------------------------
// npm_rsp_if: response channel
// Valid/ready channel carrying one nearest point result.
// ----------------------------------------------------------------------------
interface npm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [npm_pkg::IDX_BITS-1:0]  match_index;
   logic [npm_pkg::DIST_BITS-1:0] dist_sq;
   logic                          found;
   logic                          accepted;

   modport source (output valid, match_index, dist_sq, found, accepted,
                   input ready);
   modport sink   (input valid, match_index, dist_sq, found, accepted,
                   output ready);
endinterface

>>> src/npm_ram.sv
// ----------------------------------------------------------------------------
// npm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module npm_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/npm_front.sv
// ----------------------------------------------------------------------------
// npm_front: request intake and command queue
// Accepts request items, classifies them into load, query or skip commands
// and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module npm_front (
   input  logic             clock,
   input  logic             reset,
   npm_req_if.sink          req_chan,
   input  logic             cmd_pop,
   output logic             cmd_valid,
   output npm_pkg::cmd_type cmd
);

   npm_pkg::cmd_type                     queue_ff [npm_pkg::QUEUE_DEPTH];
   npm_pkg::cmd_type                     entry_in;
   logic [npm_pkg::QUEUE_AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [npm_pkg::QUEUE_AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [npm_pkg::QUEUE_CNT_BITS-1:0]   count_ff, count_in;
   logic                                 push;
   logic                                 in_range;

   assign req_chan.ready = (count_ff != npm_pkg::QUEUE_CNT_BITS'(npm_pkg::QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign in_range       = (32'(req_chan.point_index) < npm_pkg::MAX_POINTS);

   always_comb begin
      entry_in.point_index = req_chan.point_index;
      entry_in.coord_x     = req_chan.coord_x;
      entry_in.coord_y     = req_chan.coord_y;
      entry_in.coord_z     = req_chan.coord_z;
      if (req_chan.kind == npm_pkg::KIND_QUERY) begin
         entry_in.op = npm_pkg::OP_QUERY;
      end else if (in_range) begin
         entry_in.op = npm_pkg::OP_LOAD;
      end else begin
         entry_in.op = npm_pkg::OP_SKIP;
      end
   end

   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + npm_pkg::QUEUE_CNT_BITS'(push)
                           - npm_pkg::QUEUE_CNT_BITS'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

endmodule

>>> src/npm_back.sv
// ----------------------------------------------------------------------------
// npm_back: point store and scan engine
// Writes load commands into the point store and runs queries as a pipelined
// scan over the store, one point per cycle, with a registered result slot.
// ----------------------------------------------------------------------------
module npm_back (
   input  logic             clock,
   input  logic             reset,
   input  npm_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   input  npm_pkg::cmd_type cmd,
   output logic             cmd_pop,
   npm_rsp_if.source        rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   localparam int C = npm_pkg::COORD_BITS;

   state_type                            state_ff, state_in;

   logic signed [C-1:0]                  q_x_ff, q_y_ff, q_z_ff;
   logic signed [C-1:0]                  q_x_in, q_y_in, q_z_in;
   logic [npm_pkg::USE_BITS-1:0]         n_ff, n_in;
   logic [npm_pkg::USE_BITS-1:0]         issue_cnt_ff, issue_cnt_in;

   logic                                 ram_we, ram_re;
   logic [npm_pkg::POINT_BITS-1:0]       ram_rdata;
   logic signed [C-1:0]                  r_x, r_y, r_z;

   logic                                 rd_v_ff, rd_v_in;
   logic [npm_pkg::IDX_BITS-1:0]         rd_idx_ff, rd_idx_in;
   logic                                 m_v_ff;
   logic [npm_pkg::IDX_BITS-1:0]         m_idx_ff;
   logic [C-1:0]                         mag_x_ff, mag_y_ff, mag_z_ff;
   logic                                 sq_v_ff;
   logic [npm_pkg::IDX_BITS-1:0]         sq_idx_ff;
   logic [npm_pkg::SQ_BITS-1:0]          sq_x_ff, sq_y_ff, sq_z_ff;
   logic                                 s_v_ff;
   logic [npm_pkg::IDX_BITS-1:0]         s_idx_ff;
   logic [npm_pkg::DIST_BITS-1:0]        sum_ff;

   logic                                 found_ff, found_in;
   logic [npm_pkg::IDX_BITS-1:0]         best_idx_ff, best_idx_in;
   logic [npm_pkg::DIST_BITS-1:0]        best_d_ff, best_d_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_load;
   logic [npm_pkg::IDX_BITS-1:0]         rsp_idx_ff;
   logic [npm_pkg::DIST_BITS-1:0]        rsp_dist_ff;
   logic                                 rsp_found_ff, rsp_acc_ff;

   logic                                 issue;
   logic                                 pipe_busy;
   logic                                 out_free;

   npm_ram #(
      .WIDTH (npm_pkg::POINT_BITS),
      .DEPTH (npm_pkg::MAX_POINTS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (cmd.point_index),
      .wdata ({cmd.coord_x, cmd.coord_y, cmd.coord_z}),
      .re    (ram_re),
      .raddr (rd_idx_in),
      .rdata (ram_rdata)
   );

   assign r_x = $signed(ram_rdata[3*C-1:2*C]);
   assign r_y = $signed(ram_rdata[2*C-1:C]);
   assign r_z = $signed(ram_rdata[C-1:0]);

   assign issue     = (state_ff == ST_SCAN) && (issue_cnt_ff < n_ff);
   assign pipe_busy = rd_v_ff || m_v_ff || sq_v_ff || s_v_ff;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      q_x_in       = q_x_ff;
      q_y_in       = q_y_ff;
      q_z_in       = q_z_ff;
      n_in         = n_ff;
      issue_cnt_in = issue_cnt_ff;
      rd_v_in      = 1'b0;
      rd_idx_in    = rd_idx_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_d_in    = best_d_ff;

      // strict less-than keeps the lowest index on ties
      if (s_v_ff && (!found_ff || (sum_ff < best_d_ff))) begin
         found_in    = 1'b1;
         best_idx_in = s_idx_ff;
         best_d_in   = sum_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  npm_pkg::OP_LOAD: begin
                     ram_we = 1'b1;
                  end
                  npm_pkg::OP_QUERY: begin
                     q_x_in       = cmd.coord_x;
                     q_y_in       = cmd.coord_y;
                     q_z_in       = cmd.coord_z;
                     n_in         = (cfg.points_in_use >
                                     npm_pkg::USE_BITS'(npm_pkg::MAX_POINTS)) ?
                                    npm_pkg::USE_BITS'(npm_pkg::MAX_POINTS) :
                                    cfg.points_in_use;
                     issue_cnt_in = '0;
                     found_in     = 1'b0;
                     best_idx_in  = '0;
                     best_d_in    = '0;
                     state_in     = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               ram_re       = 1'b1;
               rd_v_in      = 1'b1;
               rd_idx_in    = issue_cnt_ff[npm_pkg::IDX_BITS-1:0];
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end else if (!pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_v_ff      <= 1'b0;
         m_v_ff       <= 1'b0;
         sq_v_ff      <= 1'b0;
         s_v_ff       <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         issue_cnt_ff <= '0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rd_v_ff      <= rd_v_in;
         m_v_ff       <= rd_v_ff;
         sq_v_ff      <= m_v_ff;
         s_v_ff       <= sq_v_ff;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_cnt_ff <= issue_cnt_in;
         n_ff         <= n_in;
      end
   end

   // distance pipeline: abs differences, squares, sum
   always_ff @(posedge clock) begin
      q_x_ff      <= q_x_in;
      q_y_ff      <= q_y_in;
      q_z_ff      <= q_z_in;
      rd_idx_ff   <= rd_idx_in;
      m_idx_ff    <= rd_idx_ff;
      mag_x_ff    <= npm_pkg::abs_diff(q_x_ff, r_x);
      mag_y_ff    <= npm_pkg::abs_diff(q_y_ff, r_y);
      mag_z_ff    <= npm_pkg::abs_diff(q_z_ff, r_z);
      sq_idx_ff   <= m_idx_ff;
      sq_x_ff     <= npm_pkg::SQ_BITS'(mag_x_ff) * npm_pkg::SQ_BITS'(mag_x_ff);
      sq_y_ff     <= npm_pkg::SQ_BITS'(mag_y_ff) * npm_pkg::SQ_BITS'(mag_y_ff);
      sq_z_ff     <= npm_pkg::SQ_BITS'(mag_z_ff) * npm_pkg::SQ_BITS'(mag_z_ff);
      s_idx_ff    <= sq_idx_ff;
      sum_ff      <= npm_pkg::DIST_BITS'(sq_x_ff) + npm_pkg::DIST_BITS'(sq_y_ff)
                   + npm_pkg::DIST_BITS'(sq_z_ff);
      best_idx_ff <= best_idx_in;
      best_d_ff   <= best_d_in;
      if (rsp_load) begin
         rsp_idx_ff   <= best_idx_ff;
         rsp_dist_ff  <= best_d_ff;
         rsp_found_ff <= found_ff;
         rsp_acc_ff   <= found_ff && (best_d_ff < cfg.match_limit_sq);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.match_index = rsp_idx_ff;
   assign rsp_chan.dist_sq     = rsp_dist_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.accepted    = rsp_acc_ff;

endmodule

>>> src/nearest_point_match_unit.sv
// ----------------------------------------------------------------------------
// nearest_point_match_unit: brute-force 3-D nearest point search
// Holds up to 1024 reference points and answers nearest point queries.
// ----------------------------------------------------------------------------
// A load item returns no result. A query scans the first points_in_use
// entries (points_in_use capped at 1024): the scan reads the point store
// through its single read port, one point per cycle, and a four-stage
// distance pipeline (read, abs difference, square, sum) drains before the
// result is registered. Up to two items wait in the front queue while a
// query runs, and a finished result waits in its own output register
// without blocking later loads. The point store is not cleared at reset;
// a query must only scan entries that have been loaded.
// Configuration registers must be written while the unit is idle.
module nearest_point_match_unit (
   input  logic                                clock,
   input  logic                                reset,
   npm_req_if.sink                             req_chan,
   npm_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [npm_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [npm_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   npm_pkg::cfg_type cfg_ff, cfg_in;
   npm_pkg::cmd_type cmd;
   logic             cmd_valid;
   logic             cmd_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            npm_pkg::REG_POINTS_IN_USE: begin
               cfg_in.points_in_use = csr_wdata[npm_pkg::USE_BITS-1:0];
            end
            npm_pkg::REG_MATCH_LIMIT_SQ: begin
               cfg_in.match_limit_sq = csr_wdata[npm_pkg::DIST_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.points_in_use  <= '0;
         cfg_ff.match_limit_sq <= npm_pkg::LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   npm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_pop   (cmd_pop),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   npm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> src/npm_checker.sv
// ----------------------------------------------------------------------------
// npm_checker: port-level checks for the nearest point match unit
// Watches the response channel and checks result consistency over time.
// ----------------------------------------------------------------------------
module npm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [npm_pkg::IDX_BITS-1:0]  rsp_match_index,
   input logic [npm_pkg::DIST_BITS-1:0] rsp_dist_sq,
   input logic                          rsp_found,
   input logic                          rsp_accepted
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable({rsp_match_index, rsp_dist_sq, rsp_found, rsp_accepted}))
      else $error("stalled result changed");

   a_acc_needs_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_found)
      else $error("accepted without a found point");

   // empty scan reports index and distance of zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_match_index == '0) && (rsp_dist_sq == '0))
      else $error("empty scan with nonzero fields");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind nearest_point_match_unit npm_checker u_npm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_match_index (rsp_chan.match_index),
   .rsp_dist_sq     (rsp_chan.dist_sq),
   .rsp_found       (rsp_chan.found),
   .rsp_accepted    (rsp_chan.accepted)
);
